### hw/rtl/lhcg_pkg.sv
// Package for the load/heat compression governor.
// Holds field widths, governor constants, state and mode types and the divide-by-ten helper.
// No dependencies.
package lhcg_pkg;

	localparam int CNT_W    = 64;
	localparam int PCT_W    = 7;
	localparam int FREED_W  = 21;
	localparam int HELD_W   = 40;
	localparam int REF_W    = 32;
	localparam int PM_W     = 10;
	localparam int SUM_W    = 48;

	// digit-serial subtractor
	localparam int DIGIT_W  = 4;
	localparam int NDIGIT   = CNT_W / DIGIT_W;
	localparam int DCNT_W   = $clog2(NDIGIT);

	// shared restoring divider: quotients stay below 1024
	localparam int QBITS    = 10;
	localparam int DEN_W    = HELD_W + 1;
	localparam int REM_W    = DEN_W + 1;

	localparam logic [REF_W-1:0] REF_RESET    = 32'd20000;
	localparam logic [PM_W-1:0]  PM_FULL      = 10'd1000;
	localparam logic [PM_W-1:0]  LOAD_HOT     = 10'd500;
	localparam logic [PM_W-1:0]  LOAD_SURGE   = 10'd800;
	localparam logic [PM_W-1:0]  KEEP_FLOOR   = 10'd300;
	localparam logic [PM_W-1:0]  HEAT_DECAY   = 10'd50;
	localparam logic [PM_W-1:0]  KEEP_STEP    = 10'd100;
	localparam logic [3:0]       PCT_SCALE    = 4'd10;
	localparam logic [2:0]       DROP_NUM     = 3'd7;
	localparam logic [12:0]      RECIP10      = 13'd6554;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SUB  = 6'b000010,
		ST_PREP = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_UPD  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		MODE_COLD    = 2'd0,
		MODE_HOT     = 2'd1,
		MODE_SURGING = 2'd2,
		MODE_COOLING = 2'd3
	} mode_t;

	// floor(x / 10) by reciprocal, exact for x below 8192
	function automatic logic [PM_W-1:0] div10(input logic [12:0] x);
		logic [25:0] prod;
		prod = x * RECIP10;
		return prod[25:16];
	endfunction

endpackage

### hw/rtl/load_heat_compression_governor_core.sv
// Load/heat compression governor: one tick in, one governor state update out.
// Depends on lhcg_pkg.
//
// Each accepted tick runs these steps before the next tick can be transferred: the
// 64-bit count difference, which a 4-bit digit-serial subtractor forms while it also
// shifts the new count into the last-count register, then setup, then the shared
// one-bit-per-cycle restoring divider for the I/O load (skipped when the difference
// reaches the reference), then the update, then the same divider again for the
// cooling amount when relief is active and bytes were freed, then result hand-off
// and return to idle.
// The input is stalled while a tick is in progress; a finished result waits in the
// output register while the next tick is taken, and a tick whose result finds that
// register still stalled holds in its hand-off cycle until the old result leaves.
// The reference register accepts writes at any cycle and must only be written while
// the block is idle.
module load_heat_compression_governor_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lhcg_pkg::REF_W-1:0]      cfg_data,
	// tick input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lhcg_pkg::CNT_W-1:0]      op_count,
	input  logic [lhcg_pkg::PCT_W-1:0]      mem_pressure_pct,
	input  logic [lhcg_pkg::FREED_W-1:0]    freed_bytes,
	input  logic [lhcg_pkg::HELD_W-1:0]     held_bytes,
	// result output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lhcg_pkg::PM_W-1:0]       heat,
	output logic [lhcg_pkg::PM_W-1:0]       keep_raw_permille,
	output logic [1:0]                      mode,
	output logic                            relief_active,
	output logic [lhcg_pkg::PM_W-1:0]       load,
	output logic [lhcg_pkg::SUM_W-1:0]      cooled_total
);
	import lhcg_pkg::*;

	state_t               state_q;
	logic [DCNT_W-1:0]    dcnt_q;

	logic [REF_W-1:0]     ref_q;
	logic [CNT_W-1:0]     last_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     diff_q;
	logic                 borrow_q;
	logic [PCT_W-1:0]     pct_q;
	logic [FREED_W-1:0]   freed_q;
	logic [HELD_W-1:0]    held_q;

	logic                 io_sat_q;
	logic                 cool_q;
	logic                 second_q;

	logic [REM_W-2:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [QBITS-1:0]     num_q;
	logic [QBITS-1:0]     quo_q;

	logic [PM_W-1:0]      heat_q;
	logic [PM_W-1:0]      keep_q;
	mode_t                mode_q;
	logic [PM_W-1:0]      load_q;
	logic                 relief_q;
	logic [SUM_W-1:0]     cooled_q;

	logic                 out_valid_q;
	logic [PM_W-1:0]      heat_out_q;
	logic [PM_W-1:0]      keep_out_q;
	mode_t                mode_out_q;
	logic                 relief_out_q;
	logic [PM_W-1:0]      load_out_q;

	logic                 in_xfer;
	logic                 slot_free;

	// digit-serial subtract
	logic [DIGIT_W:0]     dsub;

	// setup of the I/O division
	logic [REF_W-1:0]     ref_eff;
	logic                 diff_sat;
	logic [REF_W+QBITS-1:0] io_num;

	// divider step
	logic [REM_W-1:0]     rem_sh;
	logic                 fits;
	logic [REM_W-1:0]     rem_sub;

	// tick update
	logic [PM_W:0]        mem_raw;
	logic [PM_W-1:0]      mem_pm;
	logic [PM_W-1:0]      io_load;
	logic [PM_W-1:0]      load_c;
	logic [PM_W:0]        heat_up;
	logic [PM_W-1:0]      drop;
	logic [PM_W:0]        keep_up;
	logic [PM_W-1:0]      heat_n;
	logic [PM_W-1:0]      keep_n;
	mode_t                mode_n;
	logic                 relief_n;
	logic [FREED_W+QBITS-1:0] cool_num;
	logic [PM_W-1:0]      heat_cooled;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign dsub = {1'b0, cnt_q[DIGIT_W-1:0]} - {1'b0, last_q[DIGIT_W-1:0]}
		- {{DIGIT_W{1'b0}}, borrow_q};

	assign ref_eff  = (ref_q == '0) ? {{(REF_W-1){1'b0}}, 1'b1} : ref_q;
	assign diff_sat = (diff_q[CNT_W-1:REF_W] != '0) || (diff_q[REF_W-1:0] >= ref_eff);
	assign io_num   = {{QBITS{1'b0}}, diff_q[REF_W-1:0]} * {{REF_W{1'b0}}, PM_FULL};

	assign rem_sh  = {rem_q, num_q[QBITS-1]};
	assign fits    = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_comb begin
		mem_raw  = {4'b0, pct_q} * {7'b0, PCT_SCALE};
		mem_pm   = (mem_raw > {1'b0, PM_FULL}) ? PM_FULL : mem_raw[PM_W-1:0];
		io_load  = io_sat_q ? PM_FULL : quo_q;
		load_c   = (io_load > mem_pm) ? io_load : mem_pm;
		heat_up  = {1'b0, heat_q} + {1'b0, div10({3'b0, load_c})};
		drop     = div10({3'b0, load_c} * {10'b0, DROP_NUM});
		keep_up  = {1'b0, keep_q} + {1'b0, KEEP_STEP};
		if (load_c >= LOAD_HOT) begin
			heat_n = (heat_up > {1'b0, PM_FULL}) ? PM_FULL : heat_up[PM_W-1:0];
			keep_n = ((PM_FULL - drop) < KEEP_FLOOR) ? KEEP_FLOOR : PM_FULL - drop;
			mode_n = (load_c > LOAD_SURGE) ? MODE_SURGING : MODE_HOT;
		end else begin
			heat_n = (heat_q > HEAT_DECAY) ? heat_q - HEAT_DECAY : '0;
			keep_n = (keep_up > {1'b0, PM_FULL}) ? PM_FULL : keep_up[PM_W-1:0];
			mode_n = (keep_n < PM_FULL) ? MODE_COOLING : MODE_COLD;
		end
		relief_n    = (keep_n < PM_FULL);
		cool_num    = {{QBITS{1'b0}}, freed_q} * {{FREED_W{1'b0}}, PM_FULL};
		heat_cooled = (heat_q > quo_q) ? heat_q - quo_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ref_q <= cfg_data;
		end
	end

	// control and governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dcnt_q      <= '0;
			last_q      <= '0;
			heat_q      <= '0;
			keep_q      <= PM_FULL;
			mode_q      <= MODE_COLD;
			cooled_q    <= '0;
			out_valid_q <= 1'b0;
			io_sat_q    <= 1'b0;
			cool_q      <= 1'b0;
			second_q    <= 1'b0;
			borrow_q    <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						dcnt_q   <= '0;
						borrow_q <= 1'b0;
						state_q  <= ST_SUB;
					end
				end
				ST_SUB: begin
					// shift the new count into last_q as the old one leaves
					last_q   <= {cnt_q[DIGIT_W-1:0], last_q[CNT_W-1:DIGIT_W]};
					borrow_q <= dsub[DIGIT_W];
					dcnt_q   <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(NDIGIT - 1)) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					io_sat_q <= diff_sat;
					second_q <= 1'b0;
					dcnt_q   <= '0;
					state_q  <= diff_sat ? ST_UPD : ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(QBITS - 1)) begin
						state_q <= second_q ? ST_DONE : ST_UPD;
					end
				end
				ST_UPD: begin
					heat_q   <= heat_n;
					keep_q   <= keep_n;
					mode_q   <= mode_n;
					cool_q   <= relief_n && (freed_q != '0);
					second_q <= 1'b1;
					dcnt_q   <= '0;
					state_q  <= (relief_n && (freed_q != '0)) ? ST_DIV : ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register can take the result
					if (slot_free) begin
						if (cool_q) begin
							heat_q   <= heat_cooled;
							cooled_q <= cooled_q + {{(SUM_W-FREED_W){1'b0}}, freed_q};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cnt_q   <= op_count;
					pct_q   <= mem_pressure_pct;
					freed_q <= freed_bytes;
					held_q  <= held_bytes;
				end
			end
			ST_SUB: begin
				cnt_q  <= {{DIGIT_W{1'b0}}, cnt_q[CNT_W-1:DIGIT_W]};
				diff_q <= {dsub[DIGIT_W-1:0], diff_q[CNT_W-1:DIGIT_W]};
			end
			ST_PREP: begin
				rem_q <= {{(REM_W-1-REF_W){1'b0}}, io_num[REF_W+QBITS-1:QBITS]};
				num_q <= io_num[QBITS-1:0];
				den_q <= {{(DEN_W-REF_W){1'b0}}, ref_eff};
			end
			ST_DIV: begin
				rem_q <= fits ? rem_sub[REM_W-2:0] : rem_sh[REM_W-2:0];
				num_q <= {num_q[QBITS-2:0], 1'b0};
				quo_q <= {quo_q[QBITS-2:0], fits};
			end
			ST_UPD: begin
				load_q   <= load_c;
				relief_q <= relief_n;
				rem_q    <= {{(REM_W-1-FREED_W){1'b0}}, cool_num[FREED_W+QBITS-1:QBITS]};
				num_q    <= cool_num[QBITS-1:0];
				den_q    <= {1'b0, held_q} + {{(DEN_W-FREED_W){1'b0}}, freed_q};
			end
			ST_DONE: begin
				if (slot_free) begin
					heat_out_q   <= cool_q ? heat_cooled : heat_q;
					keep_out_q   <= keep_q;
					mode_out_q   <= mode_q;
					relief_out_q <= relief_q;
					load_out_q   <= load_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign heat              = heat_out_q;
	assign keep_raw_permille = keep_out_q;
	assign mode              = mode_out_q;
	assign relief_active     = relief_out_q;
	assign load              = load_out_q;
	assign cooled_total      = cooled_q;

`ifndef ASSERT_OFF
	a_xfer_starts_sub: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_SUB))
		else $error("tick transfer did not start the subtractor");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_keep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(keep_q >= KEEP_FLOOR) && (keep_q <= PM_FULL))
		else $error("keep fraction out of range");

	a_heat_range: assert property (@(posedge clk) disable iff (!arst_n)
		heat_q <= PM_FULL)
		else $error("heat above full scale");

	a_relief_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (relief_out_q == (keep_out_q != PM_FULL)))
		else $error("relief flag disagrees with keep fraction");
`endif

endmodule

### dv/tb_load_heat_compression_governor_core.sv
// Self-checking testbench for load_heat_compression_governor_core.
// Runs directed and random governor ticks against a behavioral model of the tick update.
// Depends on lhcg_pkg and the core RTL.
module tb_load_heat_compression_governor_core;
	import lhcg_pkg::*;

	typedef struct packed {
		logic [PM_W-1:0]  heat;
		logic [PM_W-1:0]  keep;
		mode_t            mode;
		logic             relief;
		logic [PM_W-1:0]  load;
		logic [SUM_W-1:0] cooled;
	} gov_status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [REF_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CNT_W-1:0]    op_count = '0;
	logic [PCT_W-1:0]    mem_pressure_pct = '0;
	logic [FREED_W-1:0]  freed_bytes = '0;
	logic [HELD_W-1:0]   held_bytes = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PM_W-1:0]     heat;
	logic [PM_W-1:0]     keep_raw_permille;
	logic [1:0]          mode;
	logic                relief_active;
	logic [PM_W-1:0]     load;
	logic [SUM_W-1:0]    cooled_total;

	// governor model state
	logic [REF_W-1:0]    ops_ref_m = REF_RESET;
	logic [CNT_W-1:0]    last_count_m = '0;
	logic [PM_W-1:0]     heat_m = '0;
	logic [PM_W-1:0]     keep_m = PM_FULL;
	mode_t               mode_m = MODE_COLD;
	logic [SUM_W-1:0]    cooled_m = '0;

	gov_status_t         expected_status_q[$];
	gov_status_t         want_r;
	int                  src_idle_pct = 0;
	int                  snk_idle_pct = 0;
	int                  mismatch_count = 0;
	int                  ticks_sent = 0;
	int                  results_checked = 0;

	load_heat_compression_governor_core DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.op_count          (op_count),
		.mem_pressure_pct  (mem_pressure_pct),
		.freed_bytes       (freed_bytes),
		.held_bytes        (held_bytes),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.heat              (heat),
		.keep_raw_permille (keep_raw_permille),
		.mode              (mode),
		.relief_active     (relief_active),
		.load              (load),
		.cooled_total      (cooled_total)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#12000000;
		$display("== FAIL ==");
		$finish;
	end

	// Advance the model by one tick and return the status it reports.
	function automatic gov_status_t governor_tick(input logic [CNT_W-1:0] cnt,
			input logic [PCT_W-1:0] pct, input logic [FREED_W-1:0] freed,
			input logic [HELD_W-1:0] held);
		gov_status_t r;
		logic [63:0] diff;
		logic [63:0] ref_eff;
		logic [63:0] cool;
		logic [63:0] quo;
		logic [10:0] mem_w;
		logic [10:0] sum_w;
		logic [12:0] drop;
		logic [PM_W-1:0] io_ld;
		logic [PM_W-1:0] mem_ld;
		logic [PM_W-1:0] ld;
		diff = cnt - last_count_m;
		ref_eff = (ops_ref_m == '0) ? 64'd1 : {32'd0, ops_ref_m};
		last_count_m = cnt;
		if (diff >= ref_eff) begin
			io_ld = PM_FULL;
		end else begin
			quo = (diff * 64'd1000) / ref_eff;
			io_ld = quo[PM_W-1:0];
		end
		mem_w = {4'd0, pct} * 11'd10;
		mem_ld = (mem_w > 11'd1000) ? PM_FULL : mem_w[PM_W-1:0];
		ld = (io_ld > mem_ld) ? io_ld : mem_ld;
		if (ld >= LOAD_HOT) begin
			sum_w = {1'b0, heat_m} + {1'b0, ld / 10'd10};
			heat_m = (sum_w > 11'd1000) ? PM_FULL : sum_w[PM_W-1:0];
			drop = {3'd0, ld} * 13'd7 / 13'd10;
			keep_m = (drop > 13'd700) ? KEEP_FLOOR : PM_FULL - drop[PM_W-1:0];
			mode_m = (ld > LOAD_SURGE) ? MODE_SURGING : MODE_HOT;
		end else begin
			sum_w = {1'b0, keep_m} + {1'b0, KEEP_STEP};
			heat_m = (heat_m > HEAT_DECAY) ? heat_m - HEAT_DECAY : '0;
			keep_m = (sum_w > 11'd1000) ? PM_FULL : sum_w[PM_W-1:0];
			mode_m = (keep_m < PM_FULL) ? MODE_COOLING : MODE_COLD;
		end
		r.relief = (keep_m < PM_FULL);
		if (r.relief && freed != '0) begin
			cool = ({43'd0, freed} * 64'd1000) / ({24'd0, held} + {43'd0, freed});
			heat_m = ({54'd0, heat_m} > cool) ? heat_m - cool[PM_W-1:0] : '0;
			cooled_m = cooled_m + {27'd0, freed};
		end
		r.heat = heat_m;
		r.keep = keep_m;
		r.mode = mode_m;
		r.load = ld;
		r.cooled = cooled_m;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at result %0d, %s: got %0d, expected %0d",
			results_checked, what, got, want);
		mismatch_count++;
	endtask

	// Check every result transfer against the oldest pending expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status_q.size() == 0) begin
				report_mismatch("result with nothing pending, load", load, 0);
			end else begin
				want_r = expected_status_q.pop_front();
				if (heat !== want_r.heat)
					report_mismatch("heat", heat, want_r.heat);
				if (keep_raw_permille !== want_r.keep)
					report_mismatch("keep_raw_permille", keep_raw_permille, want_r.keep);
				if (mode !== want_r.mode)
					report_mismatch("mode", mode, want_r.mode);
				if (relief_active !== want_r.relief)
					report_mismatch("relief_active", relief_active, want_r.relief);
				if (load !== want_r.load)
					report_mismatch("load", load, want_r.load);
				if (cooled_total !== want_r.cooled)
					report_mismatch("cooled_total", cooled_total, want_r.cooled);
			end
			results_checked++;
		end
		out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
	end

	task automatic send_tick(input logic [CNT_W-1:0] cnt, input logic [PCT_W-1:0] pct,
			input logic [FREED_W-1:0] freed, input logic [HELD_W-1:0] held);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		op_count         <= cnt;
		mem_pressure_pct <= pct;
		freed_bytes      <= freed;
		held_bytes       <= held;
		do @(posedge clk); while (in_stall);
		// drop valid after the transfer so no stale item waits at the input
		in_valid <= 1'b0;
		expected_status_q.push_back(governor_tick(cnt, pct, freed, held));
		ticks_sent++;
		@(posedge clk);
	endtask

	// Drain, let the core settle back to idle, then write the reference.
	task automatic write_ops_reference(input logic [REF_W-1:0] value);
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ops_ref_m = value;
	endtask

	task automatic test_directed_extremes();
		src_idle_pct = 7;
		snk_idle_pct = 48;
		send_tick(64'd0, 7'd0, 21'd0, 40'd0);
		// difference equal to the reference saturates the io load
		send_tick(64'd20000, 7'd0, 21'd0, 40'd0);
		// nothing held: cooling takes the full thousand
		send_tick(64'd39999, 7'd0, 21'd1000, 40'd0);
		send_tick(64'd56019, 7'd0, 21'd77, 40'd5000);
		send_tick(64'd72019, 7'd0, 21'd0, 40'd0);
		send_tick(64'd72019, 7'd50, 21'd0, 40'd0);
		send_tick(64'd72019, 7'd49, 21'd3, 40'd3);
		send_tick(64'd72019, 7'd100, 21'd0, 40'd0);
		// pressure above one hundred still caps at full load
		send_tick(64'd72019, 7'd127, 21'd0, 40'd0);
		send_tick(64'd72019, 7'd127, 21'h1FFFFF, 40'hFF_FFFF_FFFF);
		// walk keep back to full so freed bytes stop counting
		repeat (8) send_tick(64'd72019, 7'd0, 21'd12345, 40'd1);
		// counter wrap
		send_tick(64'hFFFF_FFFF_FFFF_FF00, 7'd0, 21'd0, 40'd0);
		send_tick(64'd50, 7'd0, 21'd0, 40'd0);
	endtask

	task automatic test_zero_reference();
		write_ops_reference(32'd0);
		send_tick(last_count_m, 7'd0, 21'd0, 40'd0);
		send_tick(last_count_m + 64'd1, 7'd0, 21'd9, 40'd0);
	endtask

	task automatic test_max_reference();
		write_ops_reference(32'hFFFF_FFFF);
		send_tick(last_count_m + 64'h0000_0000_FFFF_FFFE, 7'd0, 21'd0, 40'd0);
		send_tick(last_count_m + 64'h0000_0000_FFFF_FFFF, 7'd0, 21'd0, 40'd0);
		send_tick(last_count_m + 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 21'd0, 40'd0);
		send_tick(last_count_m + 64'd1, 7'd0, 21'd0, 40'd0);
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct);
		logic [63:0] ref_eff;
		logic [63:0] delta;
		logic [63:0] held_w;
		logic [PCT_W-1:0] pct;
		logic [FREED_W-1:0] freed;
		logic [REF_W-1:0] ref_val;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int i = 0; i < 500; i++) begin
			if (i % 125 == 0) begin
				case ($urandom_range(0, 5))
					0: ref_val = 32'd0;
					1: ref_val = 32'd1;
					2: ref_val = 32'hFFFF_FFFF;
					3: ref_val = REF_RESET;
					default: ref_val = $urandom >> $urandom_range(0, 31);
				endcase
				write_ops_reference(ref_val);
			end
			ref_eff = (ops_ref_m == '0) ? 64'd1 : {32'd0, ops_ref_m};
			case ($urandom_range(0, 9))
				0: delta = {$urandom, $urandom};
				1: delta = 64'($urandom_range(0, 50));
				default: delta = {$urandom, $urandom} % (ref_eff * 64'd2 + 64'd1);
			endcase
			case ($urandom_range(0, 3))
				0: pct = 7'd0;
				1: pct = PCT_W'($urandom_range(0, 49));
				2: pct = PCT_W'($urandom_range(0, 100));
				default: pct = PCT_W'($urandom_range(0, 127));
			endcase
			case ($urandom_range(0, 2))
				0: freed = 21'd0;
				1: freed = FREED_W'($urandom_range(0, 4095));
				default: freed = FREED_W'($urandom);
			endcase
			held_w = {$urandom, $urandom} >> $urandom_range(24, 64);
			send_tick(last_count_m + delta, pct, freed, held_w[HELD_W-1:0]);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_zero_reference();
		test_max_reference();
		test_random_traffic(7, 48);
		test_random_traffic(48, 7);
		test_random_traffic(0, 0);
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d ticks, %0d results checked, %0d mismatches", ticks_sent,
			results_checked, mismatch_count);
		$display("Covered field extremes, counter wrap, zero and full-scale references, idle mixes");
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### load_heat_compression_governor_core.f
hw/rtl/lhcg_pkg.sv
hw/rtl/load_heat_compression_governor_core.sv
dv/tb_load_heat_compression_governor_core.sv
